>>> src/hrbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrbp_pkg
// Types, codes and character classes for the HTTP request byte parser.
// ----------------------------------------------------------------------------
package hrbp_pkg;

    localparam int LEN_WIDTH_DEF = 32;
    localparam int NAME_LEN      = 14;

    // Parser phase, one-hot
    typedef enum logic [20:0] {
        PH_INIT       = 21'h000001,
        PH_METHOD     = 21'h000002,
        PH_PATH_START = 21'h000004,
        PH_PATH       = 21'h000008,
        PH_P_H        = 21'h000010,
        PH_P_HT       = 21'h000020,
        PH_P_HTT      = 21'h000040,
        PH_P_HTTP     = 21'h000080,
        PH_P_SLASH    = 21'h000100,
        PH_VMAJ       = 21'h000200,
        PH_VMIN       = 21'h000400,
        PH_NL1        = 21'h000800,
        PH_HSTART     = 21'h001000,
        PH_LWS        = 21'h002000,
        PH_HNAME      = 21'h004000,
        PH_SPV        = 21'h008000,
        PH_VSTART     = 21'h010000,
        PH_VALUE      = 21'h020000,
        PH_NL2        = 21'h040000,
        PH_NL3        = 21'h080000,
        PH_BODY       = 21'h100000
    } t_phase;

    typedef enum logic [1:0] {
        ST_PEND = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_DELIM  = 3'd0,
        KIND_METHOD = 3'd1,
        KIND_PATH   = 3'd2,
        KIND_PROTO  = 3'd3,
        KIND_HNAME  = 3'd4,
        KIND_HVALUE = 3'd5,
        KIND_BODY   = 3'd6
    } t_kind;

    // Number scan state of a header value
    localparam logic [1:0] NUM_SKIP   = 2'd0;
    localparam logic [1:0] NUM_DIGITS = 2'd1;
    localparam logic [1:0] NUM_DONE   = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_US    = 8'd31;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CH_US) || (b == CH_DEL);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        logic r;
        case (b) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return (b <= CH_DEL) && !is_ctl(b) && !is_special(b);
    endfunction

    // Characters of "Content-Length"
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> src/http_request_byte_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_byte_parser
// Byte-serial HTTP request checker with field tagging and body counting.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle while m_axis_tready does not stall the
// output, and returns one tagged item per byte: the byte itself, its field
// kind, a field-start flag and the request status. Each byte passes the input
// register, then the result register; the parser state update reads and
// writes the phase, header-match and length registers combinationally between
// the two. The Content-Length value saturates at 2^LEN_WIDTH - 1. Set the
// tuser restart flag on the first byte of every request; after a success or
// failure all bytes report failure until the next restart. No clearing pass
// after reset.
module http_request_byte_parser
    import hrbp_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] restart

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [1:0] status, [9:2] echo_byte, zero fill
    output logic [3:0]       m_axis_tuser    // [2:0] field_kind, [3] field_first
);

    localparam int AW = LEN_WIDTH + 4;

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_restart;

    // result register
    logic             r_out_valid;
    t_status          r_out_status;
    t_kind            r_out_kind;
    logic             r_out_first;
    logic [7:0]       r_out_byte;

    // parser state
    t_phase               r_phase,     n_phase;
    logic [LEN_WIDTH-1:0] r_body,      n_body;
    logic                 r_hdr_seen,  n_hdr_seen;
    logic [3:0]           r_name_idx,  n_name_idx;
    logic                 r_name_ok,   n_name_ok;
    logic [LEN_WIDTH-1:0] r_accum,     n_accum;
    logic [1:0]           r_num,       n_num;
    logic                 r_finished,  n_finished;

    t_status              n_status;
    t_kind                n_kind;
    logic                 n_first;

    // state as seen by this byte, after restart
    t_phase               c_phase;
    logic [LEN_WIDTH-1:0] c_body;
    logic                 c_hdr_seen;
    logic [3:0]           c_name_idx;
    logic                 c_name_ok;
    logic [LEN_WIDTH-1:0] c_accum;
    logic [1:0]           c_num;
    logic                 c_finished;

    logic                 advance;
    logic [7:0]           b;
    logic                 name_hit;
    logic [1:0]           v_num;
    logic [LEN_WIDTH-1:0] v_accum;
    logic [AW-1:0]        acc10;
    logic [LEN_WIDTH-1:0] body_dec;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign b             = r_in_byte;

    always_comb begin
        if (r_in_restart) begin
            c_phase    = PH_INIT;
            c_body     = '0;
            c_hdr_seen = 1'b0;
            c_name_idx = '0;
            c_name_ok  = 1'b1;
            c_accum    = '0;
            c_num      = NUM_SKIP;
            c_finished = 1'b0;
        end else begin
            c_phase    = r_phase;
            c_body     = r_body;
            c_hdr_seen = r_hdr_seen;
            c_name_idx = r_name_idx;
            c_name_ok  = r_name_ok;
            c_accum    = r_accum;
            c_num      = r_num;
            c_finished = r_finished;
        end
    end

    assign name_hit = c_name_ok && (c_name_idx < 4'(NAME_LEN)) && (b == name_char(c_name_idx));

    // value byte: skip spaces, optional plus sign (a minus ends the scan), then decimal digits with saturation
    assign acc10 = ({4'b0, c_accum} << 3) + ({4'b0, c_accum} << 1) + AW'(b[3:0]);

    always_comb begin
        v_num   = c_num;
        v_accum = c_accum;
        if (c_num == NUM_SKIP) begin
            if (b == CH_PLUS) begin
                v_num = NUM_DIGITS;
            end else if (b == CH_MINUS) begin
                v_num = NUM_DONE;
            end else if (b != CH_SP) begin
                v_num = NUM_DIGITS;
            end
        end
        if ((c_num == NUM_DIGITS) ||
            ((c_num == NUM_SKIP) && (b != CH_SP) && (b != CH_PLUS) && (b != CH_MINUS))) begin
            if (is_digit(b)) begin
                v_accum = (|acc10[AW-1:LEN_WIDTH]) ? '1 : acc10[LEN_WIDTH-1:0];
            end else begin
                v_num = NUM_DONE;
            end
        end
    end

    assign body_dec = (c_body != '0) ? c_body - LEN_WIDTH'(1) : c_body;

    always_comb begin
        n_phase    = c_phase;
        n_body     = c_body;
        n_hdr_seen = c_hdr_seen;
        n_name_idx = c_name_idx;
        n_name_ok  = c_name_ok;
        n_accum    = c_accum;
        n_num      = c_num;
        n_finished = c_finished;
        n_status   = ST_PEND;
        n_kind     = KIND_DELIM;
        n_first    = 1'b0;

        if (c_finished) begin
            n_status = ST_FAIL;
        end else begin
            unique case (c_phase)
                PH_INIT: begin
                    if (is_token(b)) begin
                        n_phase = PH_METHOD;
                        n_kind  = KIND_METHOD;
                        n_first = 1'b1;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_METHOD: begin
                    if (b == CH_SP) begin
                        n_phase = PH_PATH_START;
                    end else if (is_token(b)) begin
                        n_kind = KIND_METHOD;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_PATH_START, PH_PATH: begin
                    if (b == CH_SP) begin
                        n_phase = PH_P_H;
                    end else if (is_ctl(b)) begin
                        n_status = ST_FAIL;
                    end else begin
                        n_kind  = KIND_PATH;
                        n_first = (c_phase == PH_PATH_START);
                        n_phase = PH_PATH;
                    end
                end
                PH_P_H: begin
                    if (b == "H") begin
                        n_kind  = KIND_PROTO;
                        n_phase = PH_P_HT;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_P_HT: begin
                    if (b == "T") begin
                        n_kind  = KIND_PROTO;
                        n_phase = PH_P_HTT;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_P_HTT: begin
                    if (b == "T") begin
                        n_kind  = KIND_PROTO;
                        n_phase = PH_P_HTTP;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_P_HTTP: begin
                    if (b == "P") begin
                        n_kind  = KIND_PROTO;
                        n_phase = PH_P_SLASH;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_P_SLASH: begin
                    if (b == CH_SLASH) begin
                        n_kind  = KIND_PROTO;
                        n_phase = PH_VMAJ;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_VMAJ: begin
                    if (b == CH_DOT) begin
                        n_kind  = KIND_PROTO;
                        n_phase = PH_VMIN;
                    end else if (is_digit(b)) begin
                        n_kind = KIND_PROTO;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_VMIN: begin
                    if (b == CH_CR) begin
                        n_phase = PH_NL1;
                    end else if (is_digit(b)) begin
                        n_kind = KIND_PROTO;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_NL1, PH_NL2: begin
                    if (b == CH_LF) begin
                        n_phase = PH_HSTART;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_HSTART: begin
                    if (b == CH_CR) begin
                        n_phase = PH_NL3;
                    end else if (c_hdr_seen && ((b == CH_SP) || (b == CH_TAB))) begin
                        n_phase = PH_LWS;
                    end else if (is_token(b)) begin
                        // new header line: restart the name match and the number scan
                        n_kind     = KIND_HNAME;
                        n_first    = 1'b1;
                        n_accum    = '0;
                        n_num      = NUM_SKIP;
                        n_name_idx = (b == name_char(4'd0)) ? 4'd1 : 4'd0;
                        n_name_ok  = (b == name_char(4'd0));
                        n_phase    = PH_HNAME;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_LWS: begin
                    if (b == CH_CR) begin
                        n_phase = PH_NL2;
                    end else if ((b == CH_SP) || (b == CH_TAB)) begin
                        n_phase = PH_LWS;
                    end else if (is_ctl(b)) begin
                        n_status = ST_FAIL;
                    end else begin
                        n_kind  = KIND_HVALUE;
                        n_num   = v_num;
                        n_accum = v_accum;
                        n_phase = PH_VALUE;
                    end
                end
                PH_HNAME: begin
                    if (b == CH_COLON) begin
                        if (c_name_idx != 4'(NAME_LEN)) begin
                            n_name_ok = 1'b0;
                        end
                        n_phase = PH_SPV;
                    end else if (is_token(b)) begin
                        n_kind = KIND_HNAME;
                        if (name_hit) begin
                            n_name_idx = c_name_idx + 4'd1;
                        end else begin
                            n_name_ok = 1'b0;
                        end
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_SPV: begin
                    if (b == CH_SP) begin
                        n_phase = PH_VSTART;
                    end else begin
                        n_status = ST_FAIL;
                    end
                end
                PH_VSTART, PH_VALUE: begin
                    if (b == CH_CR) begin
                        // end of value line: latch the length if the name matched
                        n_hdr_seen = 1'b1;
                        if (c_name_ok && (c_name_idx == 4'(NAME_LEN))) begin
                            n_body = c_accum;
                        end
                        n_phase = PH_NL2;
                    end else if (is_ctl(b)) begin
                        n_status = ST_FAIL;
                    end else begin
                        n_kind  = KIND_HVALUE;
                        n_first = (c_phase == PH_VSTART);
                        n_num   = v_num;
                        n_accum = v_accum;
                        n_phase = PH_VALUE;
                    end
                end
                PH_NL3: begin
                    if (b != CH_LF) begin
                        n_status = ST_FAIL;
                    end else if (c_body == '0) begin
                        n_status = ST_OK;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_kind = KIND_BODY;
                    n_body = body_dec;
                    if (body_dec == '0) begin
                        n_status = ST_OK;
                    end
                end
                default: begin
                    n_status = ST_FAIL;
                end
            endcase

            if (n_status != ST_PEND) begin
                n_finished = 1'b1;
            end
            if (n_status == ST_FAIL) begin
                n_kind  = KIND_DELIM;
                n_first = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_INIT;
            r_body      <= '0;
            r_hdr_seen  <= 1'b0;
            r_name_idx  <= '0;
            r_name_ok   <= 1'b1;
            r_accum     <= '0;
            r_num       <= NUM_SKIP;
            r_finished  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_body      <= n_body;
                r_hdr_seen  <= n_hdr_seen;
                r_name_idx  <= n_name_idx;
                r_name_ok   <= n_name_ok;
                r_accum     <= n_accum;
                r_num       <= n_num;
                r_finished  <= n_finished;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser[0];
        end
        if (advance) begin
            r_out_status <= n_status;
            r_out_kind   <= n_kind;
            r_out_first  <= n_first;
            r_out_byte   <= r_in_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_byte, r_out_status};
    assign m_axis_tuser  = {r_out_first, r_out_kind};

`ifndef NO_ASSERTIONS
    a_done_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_finished && !r_in_restart) |=> (r_out_status == ST_FAIL))
        else $error("item after a terminal result did not report failure");

    a_fail_untagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FAIL)) |->
        ((r_out_kind == KIND_DELIM) && !r_out_first))
        else $error("failure item carries a field tag");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_BODY) && !r_finished) |-> (r_body != '0))
        else $error("body phase with no bytes left");

    a_name_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_idx <= 4'(NAME_LEN))
        else $error("header name match index out of range");

    a_ok_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_status != ST_PEND)) |=> r_finished)
        else $error("terminal result did not latch finished");
`endif

endmodule
`default_nettype wire
